@@ rtl/rds_eon_pkg.sv @@
// ----------------------------------------------------------------------------
// RDS EON package
// Types, constants and helpers shared by the group 14 other-network table.
// ----------------------------------------------------------------------------
package rds_eon_pkg;

    // group and variant codes
    localparam logic [3:0] GROUP_EON    = 4'hE;
    localparam logic [3:0] VAR_PS_LAST  = 4'd3;
    localparam logic [3:0] VAR_AF_FIRST = 4'd4;
    localparam logic [3:0] VAR_AF_LAST  = 4'd9;
    localparam logic [3:0] VAR_LINKAGE  = 4'd12;
    localparam logic [3:0] VAR_PTY_TA   = 4'd13;
    localparam logic [3:0] VAR_PIN      = 4'd14;

    localparam logic       VERSION_A    = 1'b0;
    localparam logic [2:0] NO_AF_PAIR   = 3'd6;

    // AF code to frequency in 100 kHz units
    localparam logic [7:0]  AF_CODE_MIN = 8'd1;
    localparam logic [7:0]  AF_CODE_MAX = 8'd204;
    localparam logic [10:0] AF_BASE     = 11'd875;

    typedef struct packed {
        logic [15:0] pi;
        logic        tp;
        logic        ta;
        logic [4:0]  pty;
        logic [15:0] pin;
        logic [15:0] linkage;
        logic [63:0] ps_name;
    } eon_entry_t;

    typedef struct packed {
        logic        accepted;
        logic        table_full_drop;
        eon_entry_t  ent;
        logic [2:0]  af_pair_slot;
        logic [10:0] af_first;
        logic [10:0] af_second;
    } eon_result_t;

    localparam int ENTRY_W = $bits(eon_entry_t);

    function automatic logic [10:0] af_code_to_freq(input logic [7:0] code);
        logic [10:0] freq;
        freq = '0;
        if (code >= AF_CODE_MIN && code <= AF_CODE_MAX)
        begin
            freq = AF_BASE + {3'b000, code};
        end
        return freq;
    endfunction

endpackage

@@ rtl/rds_eon_group_if.sv @@
// ----------------------------------------------------------------------------
// RDS EON group channel
// Valid/ready channel carrying one decoded RDS group.
// ----------------------------------------------------------------------------
interface rds_eon_group_if;
    logic        valid;
    logic        ready;
    logic [3:0]  group_code;
    logic        type_version;
    logic [15:0] block_b;
    logic [15:0] block_c;
    logic [15:0] block_d;
    logic        station_change;

    modport source (
        output valid, group_code, type_version, block_b, block_c, block_d, station_change,
        input  ready
    );
    modport sink (
        input  valid, group_code, type_version, block_b, block_c, block_d, station_change,
        output ready
    );
endinterface

@@ rtl/rds_eon_result_if.sv @@
// ----------------------------------------------------------------------------
// RDS EON result channel
// Valid/ready channel carrying the updated other-network entry.
// ----------------------------------------------------------------------------
interface rds_eon_result_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        table_full_drop;
    logic [15:0] net_pi;
    logic        net_tp;
    logic        net_ta;
    logic [4:0]  net_pty;
    logic [15:0] net_pin;
    logic [15:0] net_linkage;
    logic [63:0] net_ps_name;
    logic [2:0]  af_pair_slot;
    logic [10:0] af_first;
    logic [10:0] af_second;

    modport source (
        output valid, accepted, table_full_drop, net_pi, net_tp, net_ta, net_pty,
               net_pin, net_linkage, net_ps_name, af_pair_slot, af_first, af_second,
        input  ready
    );
    modport sink (
        input  valid, accepted, table_full_drop, net_pi, net_tp, net_ta, net_pty,
               net_pin, net_linkage, net_ps_name, af_pair_slot, af_first, af_second,
        output ready
    );
endinterface

@@ rtl/rds_eon_ram.sv @@
// ----------------------------------------------------------------------------
// RDS EON RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rds_eon_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/rds_eon_group_table.sv @@
// ----------------------------------------------------------------------------
// RDS EON group table
// Group 14 (Enhanced Other Networks) decoder keeping a table of other networks.
// ----------------------------------------------------------------------------
// Each accepted beat is one decoded RDS group; each group yields exactly one
// result beat. Entries live in a RAM with a registered read port, one entry
// per row, with a valid bit per row in flip-flops; station_change clears the
// valid bits at once, so there is no clearing pass after reset. A group 14
// walks the table one row per cycle looking for its PI, then writes the
// updated row back, or fills the lowest free row if its PI is not found;
// with no row free the group is dropped. The search reads the rows one by
// one through the RAM read port. One group is in work at a time; the
// next group is taken while the previous result still waits in the output
// register. AF pairs are reported in the result of the group that carries
// them and are not kept in the table.
module rds_eon_group_table #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    rds_eon_group_if.sink           grp,
    rds_eon_result_if.source        res
);
    localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_MODIFY,
        ST_EMIT
    } state_t;

    // control
    state_t                    state_reg, state_next;
    logic [TABLE_ENTRIES-1:0]  valid_reg, valid_next;
    logic [IDXW-1:0]           idx_reg, idx_next;
    logic                      chk_reg, chk_next;
    logic                      free_found_reg, free_found_next;
    logic                      out_valid_reg, out_valid_next;

    // payload
    logic                      ver_reg, ver_next;
    logic [15:0]               bb_reg, bb_next;
    logic [15:0]               bc_reg, bc_next;
    logic [15:0]               bd_reg, bd_next;
    logic                      chk_vld_reg, chk_vld_next;
    logic [IDXW-1:0]           chk_idx_reg, chk_idx_next;
    logic [IDXW-1:0]           free_idx_reg, free_idx_next;
    logic [IDXW-1:0]           slot_reg, slot_next;
    rds_eon_pkg::eon_entry_t   ent_reg, ent_next;
    rds_eon_pkg::eon_result_t  res_reg, res_next;
    rds_eon_pkg::eon_result_t  out_reg, out_next;

    // RAM
    logic                            ram_we;
    logic                            ram_re;
    logic [rds_eon_pkg::ENTRY_W-1:0] ram_rdata;
    rds_eon_pkg::eon_entry_t         rd_entry;

    // update path
    rds_eon_pkg::eon_entry_t   upd_entry;
    logic [2:0]                upd_pair;
    logic [10:0]               upd_f1;
    logic [10:0]               upd_f2;
    logic [3:0]                variant;

    logic                      hit;
    logic                      out_free;
    rds_eon_pkg::eon_result_t  empty_res;

    rds_eon_ram #(
        .WIDTH (rds_eon_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (upd_entry),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry = rds_eon_pkg::eon_entry_t'(ram_rdata);
    assign ram_re   = (state_reg == ST_SEARCH);
    assign ram_we   = (state_reg == ST_MODIFY);
    assign hit      = chk_reg && chk_vld_reg && (rd_entry.pi == bd_reg);
    assign out_free = !out_valid_reg || res.ready;
    assign variant  = bb_reg[3:0];

    always_comb
    begin
        empty_res              = '0;
        empty_res.af_pair_slot = rds_eon_pkg::NO_AF_PAIR;
    end

    // apply the group to the selected entry
    always_comb
    begin
        upd_entry    = ent_reg;
        upd_pair     = rds_eon_pkg::NO_AF_PAIR;
        upd_f1       = '0;
        upd_f2       = '0;
        upd_entry.pi = bd_reg;
        upd_entry.tp = bb_reg[4];
        if (ver_reg == rds_eon_pkg::VERSION_A)
        begin
            case (variant) inside
                [4'd0:rds_eon_pkg::VAR_PS_LAST]:
                begin
                    case (variant[1:0])
                        2'd0:    upd_entry.ps_name[63:48] = bc_reg;
                        2'd1:    upd_entry.ps_name[47:32] = bc_reg;
                        2'd2:    upd_entry.ps_name[31:16] = bc_reg;
                        default: upd_entry.ps_name[15:0]  = bc_reg;
                    endcase
                end
                [rds_eon_pkg::VAR_AF_FIRST:rds_eon_pkg::VAR_AF_LAST]:
                begin
                    upd_pair = 3'(variant - rds_eon_pkg::VAR_AF_FIRST);
                    upd_f1   = rds_eon_pkg::af_code_to_freq(bc_reg[15:8]);
                    upd_f2   = rds_eon_pkg::af_code_to_freq(bc_reg[7:0]);
                end
                rds_eon_pkg::VAR_LINKAGE:
                begin
                    upd_entry.linkage = bc_reg;
                end
                rds_eon_pkg::VAR_PTY_TA:
                begin
                    upd_entry.pty = bc_reg[15:11];
                    upd_entry.ta  = bc_reg[0];
                end
                rds_eon_pkg::VAR_PIN:
                begin
                    upd_entry.pin = bc_reg;
                end
                default:
                begin
                    // only PI and TP change
                end
            endcase
        end
        else
        begin
            upd_entry.ta = bb_reg[3];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        idx_next        = idx_reg;
        chk_next        = chk_reg;
        free_found_next = free_found_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        ver_next        = ver_reg;
        bb_next         = bb_reg;
        bc_next         = bc_reg;
        bd_next         = bd_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        free_idx_next   = free_idx_reg;
        slot_next       = slot_reg;
        ent_next        = ent_reg;
        res_next        = res_reg;
        out_next        = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (grp.valid)
                begin
                    ver_next = grp.type_version;
                    bb_next  = grp.block_b;
                    bc_next  = grp.block_c;
                    bd_next  = grp.block_d;
                    if (grp.station_change)
                    begin
                        valid_next = '0;
                    end
                    if (grp.group_code != rds_eon_pkg::GROUP_EON)
                    begin
                        res_next   = empty_res;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        idx_next        = '0;
                        chk_next        = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                // issue a read for this row, compare the row read last cycle
                chk_next     = 1'b1;
                chk_vld_next = valid_reg[idx_reg];
                chk_idx_next = idx_reg;
                if (!valid_reg[idx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (hit)
                begin
                    ent_next   = rd_entry;
                    slot_next  = chk_idx_reg;
                    state_next = ST_MODIFY;
                end
            end
            ST_DRAIN:
            begin
                chk_next = 1'b0;
                if (hit)
                begin
                    ent_next   = rd_entry;
                    slot_next  = chk_idx_reg;
                    state_next = ST_MODIFY;
                end
                else if (free_found_reg)
                begin
                    // take the lowest free row, cleared
                    ent_next   = '0;
                    slot_next  = free_idx_reg;
                    state_next = ST_MODIFY;
                end
                else
                begin
                    res_next                 = empty_res;
                    res_next.table_full_drop = 1'b1;
                    res_next.ent.pi          = bd_reg;
                    state_next               = ST_EMIT;
                end
            end
            ST_MODIFY:
            begin
                valid_next[slot_reg]  = 1'b1;
                res_next.accepted        = 1'b1;
                res_next.table_full_drop = 1'b0;
                res_next.ent             = upd_entry;
                res_next.af_pair_slot    = upd_pair;
                res_next.af_first        = upd_f1;
                res_next.af_second       = upd_f2;
                state_next               = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            idx_reg        <= '0;
            chk_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            idx_reg        <= idx_next;
            chk_reg        <= chk_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ver_reg      <= ver_next;
        bb_reg       <= bb_next;
        bc_reg       <= bc_next;
        bd_reg       <= bd_next;
        chk_vld_reg  <= chk_vld_next;
        chk_idx_reg  <= chk_idx_next;
        free_idx_reg <= free_idx_next;
        slot_reg     <= slot_next;
        ent_reg      <= ent_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign grp.ready           = (state_reg == ST_IDLE);
    assign res.valid           = out_valid_reg;
    assign res.accepted        = out_reg.accepted;
    assign res.table_full_drop = out_reg.table_full_drop;
    assign res.net_pi          = out_reg.ent.pi;
    assign res.net_tp          = out_reg.ent.tp;
    assign res.net_ta          = out_reg.ent.ta;
    assign res.net_pty         = out_reg.ent.pty;
    assign res.net_pin         = out_reg.ent.pin;
    assign res.net_linkage     = out_reg.ent.linkage;
    assign res.net_ps_name     = out_reg.ent.ps_name;
    assign res.af_pair_slot    = out_reg.af_pair_slot;
    assign res.af_first        = out_reg.af_first;
    assign res.af_second       = out_reg.af_second;
endmodule

@@ rtl/rds_eon_chk.sv @@
// ----------------------------------------------------------------------------
// RDS EON checker
// Port-level assertions for the group 14 other-network table.
// ----------------------------------------------------------------------------
module rds_eon_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        accepted,
    input logic        table_full_drop,
    input logic        net_tp,
    input logic        net_ta,
    input logic [4:0]  net_pty,
    input logic [15:0] net_pin,
    input logic [15:0] net_linkage,
    input logic [63:0] net_ps_name,
    input logic [2:0]  af_pair_slot,
    input logic [10:0] af_first,
    input logic [10:0] af_second
);
    // hold a result beat until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before ready");

    a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(accepted && table_full_drop))
        else $error("result both accepted and dropped");

    // a group that updated no entry shows no entry data but the PI, and no AF pair
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> !net_tp && !net_ta && net_pty == 5'd0
            && net_pin == 16'd0 && net_linkage == 16'd0 && net_ps_name == 64'd0
            && af_pair_slot == rds_eon_pkg::NO_AF_PAIR
            && af_first == 11'd0 && af_second == 11'd0)
        else $error("non-updating result carries entry data");

    a_af_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && af_pair_slot != rds_eon_pkg::NO_AF_PAIR
            |-> accepted && af_pair_slot < rds_eon_pkg::NO_AF_PAIR)
        else $error("AF pair slot out of range");
endmodule

bind rds_eon_group_table rds_eon_chk u_rds_eon_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (res.valid),
    .out_ready       (res.ready),
    .accepted        (res.accepted),
    .table_full_drop (res.table_full_drop),
    .net_tp          (res.net_tp),
    .net_ta          (res.net_ta),
    .net_pty         (res.net_pty),
    .net_pin         (res.net_pin),
    .net_linkage     (res.net_linkage),
    .net_ps_name     (res.net_ps_name),
    .af_pair_slot    (res.af_pair_slot),
    .af_first        (res.af_first),
    .af_second       (res.af_second)
);
